### rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, constants, types and helpers of the escape-time counter.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRACTION_BITS = 28;
    localparam int COORD_WIDTH   = 32;
    localparam int CNT_W         = 16;

    // z stays inside +-16, c is clamped to +-8
    localparam int ZW = FRACTION_BITS + 5;
    // multiplier operand: magnitude below 2
    localparam int MW = FRACTION_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int LW = ((COORD_WIDTH > ZW) ? COORD_WIDTH : ZW) + 1;

    localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(256);
    localparam logic [ZW-1:0]    TWO       = ZW'(1) << (FRACTION_BITS + 1);
    localparam logic [PW:0]      FOUR      = (PW + 1)'(1) << (2 * FRACTION_BITS + 2);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [ZW-1:0]          t_z;
    typedef logic [ZW-1:0]                 t_zmag;
    typedef logic [MW-1:0]                 t_mag;
    typedef logic [PW-1:0]                 t_prod;
    typedef logic [CNT_W-1:0]              t_count;

    typedef struct packed {
        logic en;
        t_mag a;
        t_mag b;
    } t_mul_req;

    typedef struct packed {
        logic   valid;
        t_count count;
    } t_core_res;

    // sign-extend and clamp a coordinate to +-8
    function automatic t_z f_load(input t_coord raw);
        logic signed [LW-1:0] v;
        logic signed [LW-1:0] lim;
        v   = LW'(raw);
        lim = $signed(LW'(1) << (FRACTION_BITS + 3));
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return t_z'(v[ZW-1:0]);
    endfunction

    function automatic t_zmag f_mag(input t_z v);
        t_zmag uv;
        uv = t_zmag'(v);
        return v[ZW-1] ? (~uv + 1'b1) : uv;
    endfunction

endpackage

### rtl/core/mbe_if.sv
// ----------------------------------------------------------------------------
// mbe_if
// Valid/ready channels: point requests, results and the limit register write.
// ----------------------------------------------------------------------------
interface mbe_pt_if;
    import mbe_pkg::*;
    logic   valid;
    logic   ready;
    t_coord c_real;
    t_coord c_imag;
    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_res_if;
    import mbe_pkg::*;
    logic   valid;
    logic   ready;
    t_count escape_count;
    modport source (output valid, output escape_count, input ready);
    modport sink   (input valid, input escape_count, output ready);
endinterface

interface mbe_cfg_if;
    import mbe_pkg::*;
    logic   valid;
    logic   ready;
    t_count iteration_limit;
    modport source (output valid, output iteration_limit, input ready);
    modport sink   (input valid, input iteration_limit, output ready);
endinterface

### rtl/core/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul
// Shared unsigned magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
module mbe_mul (
    input  logic              i_clk,
    input  mbe_pkg::t_mul_req i_req,
    output mbe_pkg::t_prod    o_p
);
    import mbe_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_p <= PW'(i_req.a) * PW'(i_req.b);
        end
    end

    assign o_p = r_p;

endmodule

### rtl/core/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core
// Sequencer and z registers: states SQX, SQY, XY, UPD per z = z^2 + c step.
// ----------------------------------------------------------------------------
module mbe_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mbe_pkg::t_coord    i_c_real,
    input  mbe_pkg::t_coord    i_c_imag,
    input  mbe_pkg::t_count    i_limit,
    input  logic               i_res_ready,
    output logic               o_idle,
    output mbe_pkg::t_core_res o_res
);
    import mbe_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQX  = 6'b000010,
        ST_SQY  = 6'b000100,
        ST_XY   = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state   r_state, n_state;
    t_z       r_cx, r_cy, r_zx, r_zy;
    t_count   r_cnt;
    t_prod    r_sx, r_sy;

    t_mul_req mul_req;
    t_prod    mul_p;
    t_zmag    mx_full, my_full;
    logic     too_big;
    logic [PW:0]          sum;
    logic                 escaped;
    logic signed [PW:0]   diff, diff_sh;
    logic signed [PW:0]   sprod, sprod_sh;
    logic                 neg;
    t_z                   zx_new, zy_new;

    mbe_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    assign mx_full = f_mag(r_zx);
    assign my_full = f_mag(r_zy);
    assign too_big = (mx_full >= TWO) || (my_full >= TWO);

    // in ST_XY the product register holds zy^2
    assign sum     = {1'b0, r_sx} + {1'b0, mul_p};
    assign escaped = (sum >= FOUR);

    // in ST_UPD the product register holds |zx*zy|
    assign diff     = $signed({1'b0, r_sx}) - $signed({1'b0, r_sy});
    assign diff_sh  = diff >>> FRACTION_BITS;
    assign neg      = r_zx[ZW-1] ^ r_zy[ZW-1];
    assign sprod    = neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
    assign sprod_sh = sprod >>> (FRACTION_BITS - 1);
    assign zx_new   = $signed(diff_sh[ZW-1:0]) + r_cx;
    assign zy_new   = $signed(sprod_sh[ZW-1:0]) + r_cy;

    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = mx_full[MW-1:0];
        mul_req.b  = mx_full[MW-1:0];
        unique case (r_state)
            ST_SQX: begin
                mul_req.en = 1'b1;
            end
            ST_SQY: begin
                mul_req.en = 1'b1;
                mul_req.a  = my_full[MW-1:0];
                mul_req.b  = my_full[MW-1:0];
            end
            ST_XY: begin
                mul_req.en = 1'b1;
                mul_req.b  = my_full[MW-1:0];
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SQX;
            end
            ST_SQX: begin
                if ((r_cnt >= i_limit) || too_big) n_state = ST_DONE;
                else                               n_state = ST_SQY;
            end
            ST_SQY: begin
                n_state = ST_XY;
            end
            ST_XY: begin
                if (escaped) n_state = ST_DONE;
                else         n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_SQX;
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_cx  <= f_load(i_c_real);
            r_cy  <= f_load(i_c_imag);
            r_zx  <= '0;
            r_zy  <= '0;
            r_cnt <= '0;
        end
        if (r_state == ST_SQY) begin
            r_sx <= mul_p;
        end
        if (r_state == ST_XY) begin
            r_sy <= mul_p;
        end
        if (r_state == ST_UPD) begin
            r_zx  <= zx_new;
            r_zy  <= zy_new;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.count = r_cnt;

endmodule

### rtl/core/mandelbrot_escape_time_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time counter for one complex point per request, Q4.28 coordinates.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_pt     in   valid/ready    c_real, c_imag (signed Q4.28)
//  o_res    out  valid/ready    escape_count (16 bit)
//  i_cfg    in   valid/ready    iteration_limit (16 bit, reset 256)
//
//  A point takes N z steps plus load, final check and hand-off: the one
//  29x29 multiplier is used three times per step (zx^2, zy^2, zx*zy) and
//  the update takes a further state.
//  i_pt.ready is high only while the sequencer is idle; the output register
//  holds one result, so a new request is taken while the last result waits.
//  A stalled o_res holds its result; the next point then waits in the core.
//  Synchronous active-low reset clears control state and sets the limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbe_pt_if.sink    i_pt,
    mbe_res_if.source o_res,
    mbe_cfg_if.sink   i_cfg
);
    import mbe_pkg::*;

    t_count    r_limit;
    logic      r_out_valid;
    t_count    r_out_count;
    logic      core_idle;
    logic      res_take;
    t_core_res core_res;

    mbe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_pt.valid),
        .i_c_real    (i_pt.c_real),
        .i_c_imag    (i_pt.c_imag),
        .i_limit     (r_limit),
        .i_res_ready (res_take),
        .o_idle      (core_idle),
        .o_res       (core_res)
    );

    assign i_pt.ready  = core_idle;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.iteration_limit;
        end
    end

    assign res_take = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res.valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res.valid && res_take) begin
            r_out_count <= core_res.count;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.escape_count = r_out_count;

endmodule

### rtl/core/mbe_chk.sv
// ----------------------------------------------------------------------------
// mbe_chk
// Port-level checks of the escape-time counter, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_pt_valid,
    input logic            i_pt_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input mbe_pkg::t_count i_res_count,
    input logic            i_cfg_valid,
    input logic            i_cfg_ready,
    input mbe_pkg::t_count i_cfg_limit
);
    import mbe_pkg::*;

    logic       pt_acc, res_acc;
    t_count     r_lim;
    logic [1:0] r_pend;

    assign pt_acc  = i_pt_valid && i_pt_ready;
    assign res_acc = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIMIT_RST;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_lim <= i_cfg_limit;
        end
    end

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, pt_acc} - {1'b0, res_acc};
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_count))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_acc |=> !i_pt_ready)
        else $error("request accepted while point in flight");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_count <= r_lim)
        else $error("escape count above limit");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_acc |-> r_pend != 2'd0)
        else $error("result without request");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_acc |-> r_pend <= 2'd1)
        else $error("more than two points outstanding");

endmodule

bind mandelbrot_escape_time_top mbe_chk u_mbe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pt_valid  (i_pt.valid),
    .i_pt_ready  (i_pt.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_count (o_res.escape_count),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_limit (i_cfg.iteration_limit)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Escape-time counter check: a directed table of corner points followed by
// randomized points under several iteration limits. Every request is scored
// against its table count or a full-width fixed-point model of z = z^2 + c,
// with random valid/ready gaps on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import mbe_pkg::*;

    localparam int          N_DIR       = 23;
    localparam int          N_PHASE     = 8;
    localparam int unsigned HOLD_CYCLES = 3000;
    // slowest request: 65535 steps
    localparam int unsigned WATCHDOG    = 1000000;

    localparam t_coord Q_ONE  = 32'sh1000_0000;
    localparam t_coord Q_TWO  = 32'sh2000_0000;
    localparam t_coord Q_QTR  = 32'sh0400_0000;
    localparam t_coord Q_MAXP = 32'sh7FFF_FFFF;
    localparam t_coord Q_MAXN = 32'sh8000_0000;
    localparam t_coord Q_M1   = 32'shFFFF_FFFF;
    localparam t_coord Q_ZERO = 32'sh0000_0000;

    typedef struct {
        t_count cnt;
        t_coord re;
        t_coord im;
    } t_escape;

    typedef struct {
        t_coord re;
        t_coord im;
    } t_point;

    typedef struct {
        bit     set_lim;
        t_count lim;
        t_coord re;
        t_coord im;
        bit     typed;
        t_count cnt;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;

    mbe_pt_if  pt_if ();
    mbe_res_if res_if ();
    mbe_cfg_if cfg_if ();

    mandelbrot_escape_time_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    t_escape     escape_fifo [$];
    t_count      lim_now     = LIMIT_RST;
    int          err_count   = 0;
    bit          src_idle_on = 1'b1;
    bit          snk_idle_on = 1'b1;
    bit          hold_req    = 1'b0;
    int unsigned quiet_cycles = 0;
    t_row        dir_tab [N_DIR];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Exact model: z kept at Q.FRACTION_BITS, squares at twice that, floor on shift.
    function automatic t_count escape_steps(input t_coord re, input t_coord im,
                                            input t_count lim);
        logic signed [63:0]  cx, cy, zx, zy, nx, clip, z_edge;
        logic signed [127:0] sx, sy, pxy, r_edge;
        t_count              n;
        bit                  done;
        clip   = 64'sd8 <<< FRACTION_BITS;
        z_edge = 64'sd2 <<< FRACTION_BITS;
        r_edge = 128'sd4 <<< (2 * FRACTION_BITS);
        cx = 64'(re);
        cy = 64'(im);
        if (cx > clip) cx = clip;
        if (cx < -clip) cx = -clip;
        if (cy > clip) cy = clip;
        if (cy < -clip) cy = -clip;
        zx   = '0;
        zy   = '0;
        n    = '0;
        done = 1'b0;
        while (!done && n < lim) begin
            if (zx >= z_edge || zx <= -z_edge || zy >= z_edge || zy <= -z_edge) begin
                done = 1'b1;
            end else begin
                sx = 128'(zx) * 128'(zx);
                sy = 128'(zy) * 128'(zy);
                if (sx + sy >= r_edge) begin
                    done = 1'b1;
                end else begin
                    pxy = 128'(zx) * 128'(zy);
                    nx  = 64'((sx - sy) >>> FRACTION_BITS) + cx;
                    zy  = 64'(pxy >>> (FRACTION_BITS - 1)) + cy;
                    zx  = nx;
                    n   = n + 16'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic t_point pick_point();
        t_point      p;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            // raw words: every bit, mostly far outside the set
            p.re = t_coord'($urandom());
            p.im = t_coord'($urandom());
        end else if (sel < 85) begin
            // [-2.5, 1.0] x [-1.5, 1.5]
            p.re = t_coord'(32'hD800_0000 + $urandom_range(0, 32'h3800_0000));
            p.im = t_coord'(32'hE800_0000 + $urandom_range(0, 32'h3000_0000));
        end else begin
            // close to the cusp or the neck of the main cardioid
            p.re = (sel[0] ? Q_QTR : -(Q_QTR * 3))
                   + t_coord'($urandom_range(0, 65535)) - 32'sd32768;
            p.im = t_coord'($urandom_range(0, 65535)) - 32'sd32768;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input t_count want, input t_count got,
                                   input t_coord re, input t_coord im);
        $display("ERROR %0t: %s c=(%h,%h) expected %0d got %0d",
                 $time, what, re, im, want, got);
        err_count++;
    endtask

    task automatic request_point(input t_coord re, input t_coord im,
                                 input bit typed, input t_count typed_cnt);
        t_escape e;
        while (src_idle_on && $urandom_range(0, 99) < 22) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid  <= 1'b1;
        pt_if.c_real <= re;
        pt_if.c_imag <= im;
        do @(posedge i_clk); while (!pt_if.ready);
        e.cnt = typed ? typed_cnt : escape_steps(re, im, lim_now);
        e.re  = re;
        e.im  = im;
        escape_fifo.push_back(e);
    endtask

    // only while nothing is in flight
    task automatic set_limit(input t_count v);
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (escape_fifo.size() != 0);
        cfg_if.valid           <= 1'b1;
        cfg_if.iteration_limit <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        lim_now = v;
    endtask

    // result sink: random stalls plus one long hold
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(snk_idle_on && $urandom_range(0, 99) < 22);
            end
        end
    end

    always @(posedge i_clk) begin
        t_escape head;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (escape_fifo.size() == 0) begin
                report_mismatch("result with no request pending", 16'd0,
                                res_if.escape_count, Q_ZERO, Q_ZERO);
            end else begin
                head = escape_fifo.pop_front();
                if (res_if.escape_count !== head.cnt) begin
                    report_mismatch("escape_count", head.cnt, res_if.escape_count,
                                    head.re, head.im);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_count ph_lim [N_PHASE];
        int     ph_items [N_PHASE];
        t_point p;

        i_rst_n                <= 1'b0;
        pt_if.valid            <= 1'b0;
        pt_if.c_real           <= Q_ZERO;
        pt_if.c_imag           <= Q_ZERO;
        cfg_if.valid           <= 1'b0;
        cfg_if.iteration_limit <= 16'd0;

        dir_tab = '{
            '{1'b0, 16'd0,     Q_ZERO,        Q_ZERO, 1'b1, 16'd256},
            '{1'b0, 16'd0,     Q_MAXP,        Q_ZERO, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_MAXN,        Q_MAXN, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_MAXP,        Q_MAXN, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_MAXN,        Q_MAXP, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_TWO,         Q_ZERO, 1'b1, 16'd1},
            '{1'b0, 16'd0,     -Q_TWO,        Q_ZERO, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_ZERO,        Q_TWO,  1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_ZERO,        -Q_TWO, 1'b1, 16'd1},
            '{1'b0, 16'd0,     -Q_ONE,        Q_ZERO, 1'b1, 16'd256},
            '{1'b0, 16'd0,     Q_ZERO,        Q_ONE,  1'b1, 16'd256},
            '{1'b0, 16'd0,     Q_ONE,         Q_ZERO, 1'b1, 16'd2},
            '{1'b0, 16'd0,     Q_QTR,         Q_ZERO, 1'b0, 16'd0},
            '{1'b0, 16'd0,     Q_TWO - 32'sd1, Q_ZERO, 1'b0, 16'd0},
            '{1'b0, 16'd0,     32'sd1 - Q_TWO, 32'sd1, 1'b0, 16'd0},
            '{1'b0, 16'd0,     Q_M1,          Q_M1,   1'b0, 16'd0},
            '{1'b1, 16'd0,     Q_ZERO,        Q_ZERO, 1'b1, 16'd0},
            '{1'b0, 16'd0,     Q_MAXP,        Q_MAXP, 1'b1, 16'd0},
            '{1'b1, 16'd1,     Q_ZERO,        Q_ZERO, 1'b1, 16'd1},
            '{1'b0, 16'd0,     Q_MAXN,        Q_ZERO, 1'b1, 16'd1},
            '{1'b1, 16'd2,     -Q_ONE,        Q_ZERO, 1'b1, 16'd2},
            '{1'b1, 16'hFFFF,  Q_ZERO,        Q_ZERO, 1'b1, 16'hFFFF},
            '{1'b0, 16'd0,     Q_MAXN,        Q_MAXN, 1'b1, 16'd1}
        };

        ph_lim   = '{16'd3, 16'd256, 16'd1, t_count'($urandom_range(4, 40)),
                     16'd64, 16'd0, 16'hFFFF, 16'd16};
        ph_items = '{125, 125, 125, 150, 125, 60, 100, 190};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].set_lim) begin
                set_limit(dir_tab[i].lim);
            end
            request_point(dir_tab[i].re, dir_tab[i].im, dir_tab[i].typed, dir_tab[i].cnt);
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            set_limit(ph_lim[ph]);
            src_idle_on = (ph != 2);
            snk_idle_on = (ph != 2);
            // hold results off while requests keep coming
            if (ph == 0) hold_req = 1'b1;
            for (int k = 0; k < ph_items[ph]; k++) begin
                p = pick_point();
                // at the top limit keep to points that escape early
                while (lim_now > 16'd1000 && escape_steps(p.re, p.im, 16'd500) >= 16'd500) begin
                    p = pick_point();
                end
                request_point(p.re, p.im, 1'b0, 16'd0);
            end
        end
        pt_if.valid <= 1'b0;

        do @(posedge i_clk); while (escape_fifo.size() != 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
